// ===== rtl/sla_pkg.sv =====
// Package with pattern codes, animation tables and fade constants for the status LED animator.
package sla_pkg;

    localparam int LevelW = 7;
    localparam int PatW   = 3;
    localparam int StepW  = 4;
    localparam int DurW   = 10;
    localparam int ElW    = 10;

    localparam logic [LevelW-1:0] LEVEL_ON = 7'd80;

    // Fade quotients divide by 25 after scaling: x / 25 == (x * 1311) >> 15 for x < 4096.
    localparam int RecipW     = 11;
    localparam int RecipShift = 15;
    localparam logic [RecipW-1:0] RECIP_25 = 11'd1311;

    localparam logic [PatW-1:0] PAT_OFF        = 3'd0;
    localparam logic [PatW-1:0] PAT_LED_RELAY  = 3'd1;
    localparam logic [PatW-1:0] PAT_LED        = 3'd2;
    localparam logic [PatW-1:0] PAT_RELAY      = 3'd3;
    localparam logic [PatW-1:0] PAT_NO_BROKER  = 3'd4;
    localparam logic [PatW-1:0] PAT_NO_WIFI    = 3'd5;
    localparam logic [PatW-1:0] PAT_IDLE       = 3'd6;
    localparam logic [PatW-1:0] PAT_NONE       = 3'd7;

    typedef struct packed {
        logic [LevelW-1:0] red;
        logic [LevelW-1:0] green;
        logic [LevelW-1:0] blue;
    } rgb_t;

    localparam rgb_t RGB_BLACK = '{red: 7'd0,  green: 7'd0,  blue: 7'd0};
    localparam rgb_t RGB_RED   = '{red: 7'd80, green: 7'd0,  blue: 7'd0};
    localparam rgb_t RGB_GREEN = '{red: 7'd0,  green: 7'd80, blue: 7'd0};
    localparam rgb_t RGB_BLUE  = '{red: 7'd0,  green: 7'd0,  blue: 7'd80};

    function automatic logic [PatW-1:0] pattern_sel(input logic led_on, input logic relay_on,
                                                    input logic wifi_up, input logic broker_up,
                                                    input logic enabled_flag);
        logic [PatW-1:0] pat;
        if (led_on && relay_on)
            pat = PAT_LED_RELAY;
        else if (led_on)
            pat = PAT_LED;
        else if (relay_on)
            pat = PAT_RELAY;
        else if (wifi_up && !broker_up)
            pat = PAT_NO_BROKER;
        else if (!wifi_up)
            pat = PAT_NO_WIFI;
        else if (enabled_flag)
            pat = PAT_IDLE;
        else
            pat = PAT_OFF;
        return pat;
    endfunction

    function automatic logic [StepW-1:0] step_count(input logic [PatW-1:0] pat);
        logic [StepW-1:0] n;
        case (pat)
            PAT_LED_RELAY: n = 4'd12;
            PAT_LED:       n = 4'd6;
            PAT_RELAY:     n = 4'd4;
            PAT_NO_BROKER: n = 4'd4;
            PAT_NO_WIFI:   n = 4'd3;
            PAT_IDLE:      n = 4'd5;
            default:       n = 4'd1;
        endcase
        return n;
    endfunction

    function automatic logic [DurW-1:0] step_length(input logic [PatW-1:0] pat,
                                                    input logic [StepW-1:0] step);
        logic [DurW-1:0] d;
        case (pat)
            PAT_LED_RELAY:
            begin
                if (step == 4'd11)
                    d = 10'd350;
                else if (step[0])
                    d = 10'd50;
                else
                    d = 10'd100;
            end
            PAT_LED:       d = step[0] ? 10'd200 : 10'd300;
            PAT_RELAY:     d = (step == 4'd3) ? 10'd700 : 10'd500;
            PAT_NO_BROKER: d = 10'd500;
            PAT_NO_WIFI:   d = (step == 4'd2) ? 10'd500 : 10'd200;
            PAT_IDLE:      d = (step == 4'd4) ? 10'd200 : 10'd1000;
            default:       d = 10'd1;
        endcase
        return d;
    endfunction

    // Colours of the stepped patterns.
    function automatic rgb_t step_colour(input logic [PatW-1:0] pat,
                                         input logic [StepW-1:0] step);
        rgb_t c;
        c = RGB_BLACK;
        case (pat)
            PAT_LED_RELAY:
            begin
                case (step)
                    4'd0, 4'd2:  c = RGB_RED;
                    4'd4, 4'd6:  c = RGB_GREEN;
                    4'd8, 4'd10: c = RGB_BLUE;
                    default:     c = RGB_BLACK;
                endcase
            end
            PAT_LED:
            begin
                case (step)
                    4'd0:    c = RGB_RED;
                    4'd2:    c = RGB_GREEN;
                    4'd4:    c = RGB_BLUE;
                    default: c = RGB_BLACK;
                endcase
            end
            PAT_RELAY:
            begin
                case (step)
                    4'd0:    c = RGB_RED;
                    4'd1:    c = RGB_GREEN;
                    4'd2:    c = RGB_BLUE;
                    default: c = RGB_BLACK;
                endcase
            end
            PAT_NO_WIFI:
            begin
                case (step)
                    4'd0:    c = RGB_RED;
                    4'd1:    c = RGB_GREEN;
                    default: c = RGB_BLACK;
                endcase
            end
            default: c = RGB_BLACK;
        endcase
        return c;
    endfunction

    // Start colour of a fade step.
    function automatic rgb_t fade_from(input logic [PatW-1:0] pat,
                                       input logic [StepW-1:0] step);
        rgb_t c;
        c = RGB_BLACK;
        if (pat == PAT_NO_BROKER)
        begin
            case (step)
                4'd0:    c = RGB_RED;
                4'd1:    c = RGB_GREEN;
                4'd3:    c = RGB_BLUE;
                default: c = RGB_BLACK;
            endcase
        end
        else
        begin
            case (step)
                4'd1:    c = RGB_RED;
                4'd2:    c = RGB_GREEN;
                4'd3:    c = RGB_BLUE;
                default: c = RGB_BLACK;
            endcase
        end
        return c;
    endfunction

    // End colour of a fade step.
    function automatic rgb_t fade_to(input logic [PatW-1:0] pat,
                                     input logic [StepW-1:0] step);
        rgb_t c;
        c = RGB_BLACK;
        if (pat == PAT_NO_BROKER)
        begin
            case (step)
                4'd0:    c = RGB_GREEN;
                4'd2:    c = RGB_BLUE;
                default: c = RGB_BLACK;
            endcase
        end
        else
        begin
            case (step)
                4'd0:    c = RGB_RED;
                4'd1:    c = RGB_GREEN;
                4'd2:    c = RGB_BLUE;
                default: c = RGB_BLACK;
            endcase
        end
        return c;
    endfunction

endpackage

// ===== rtl/sla_in_if.sv =====
// Status word channel of the status LED animator.
interface sla_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        led_on;
    logic        relay_on;
    logic        wifi_up;
    logic        broker_up;
    logic        enabled_flag;

    modport source (
        output valid, now_ms, led_on, relay_on, wifi_up, broker_up, enabled_flag,
        input  ready
    );

    modport sink (
        input  valid, now_ms, led_on, relay_on, wifi_up, broker_up, enabled_flag,
        output ready
    );
endinterface

// ===== rtl/sla_out_if.sv =====
// Pixel colour channel of the status LED animator.
interface sla_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] red;
    logic [6:0] green;
    logic [6:0] blue;
    logic [2:0] pattern_id;

    modport source (
        output valid, red, green, blue, pattern_id,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, pattern_id,
        output ready
    );
endinterface

// ===== rtl/status_led_pattern_animator.sv =====
// Status LED animator: pattern selection, step timing and colour fades for one pixel.
//
//   channel  dir   word contents
//   status   in    now_ms, led_on, relay_on, wifi_up, broker_up, enabled_flag
//   pixel    out   red, green, blue, pattern_id
//
// One status word is taken every cycle unless the pixel side stalls; its pixel word
// is registered in the input register, then in the result register.
// The pattern, step and step start time are updated when a word passes from the
// input register to the result register, so each word sees the state left by the last.
// A stalled pixel word holds the result register; the input register still takes one
// more word, and the status side stalls only when both are full.
// Reset clears both valid flags and sets the pattern state to "no pattern yet".
module status_led_pattern_animator (
    input logic        clk,
    input logic        rst_n,
    sla_in_if.sink     status,
    sla_out_if.source  pixel
);

    // Input register.
    logic        in_valid_reg;
    logic [31:0] in_now_reg;
    logic        in_led_reg;
    logic        in_relay_reg;
    logic        in_wifi_reg;
    logic        in_broker_reg;
    logic        in_en_reg;

    // Result register.
    logic                       out_valid_reg;
    sla_pkg::rgb_t              out_rgb_reg;
    logic [sla_pkg::PatW-1:0]   out_pat_reg;

    // Animation state.
    logic [sla_pkg::PatW-1:0]   prev_pat_reg;
    logic [sla_pkg::PatW-1:0]   prev_pat_next;
    logic [sla_pkg::StepW-1:0]  step_reg;
    logic [sla_pkg::StepW-1:0]  step_next;
    logic [31:0]                start_reg;
    logic [31:0]                start_next;

    logic                       proc_fire;
    logic                       out_free;

    logic [sla_pkg::PatW-1:0]   pat;
    logic [sla_pkg::StepW-1:0]  n_steps;
    logic                       pat_changed;
    logic [sla_pkg::StepW-1:0]  step_eff;
    logic [31:0]                start_eff;
    logic [31:0]                elapsed;
    logic [sla_pkg::DurW-1:0]   dur;
    logic                       step_done;
    logic [sla_pkg::StepW-1:0]  step_inc;
    logic [sla_pkg::StepW-1:0]  step_new;
    logic [sla_pkg::ElW-1:0]    el;
    logic [sla_pkg::ElW+1:0]    scaled;
    logic [sla_pkg::ElW+sla_pkg::RecipW+1:0] prod;
    logic [sla_pkg::LevelW-1:0] q;
    sla_pkg::rgb_t              c_from;
    sla_pkg::rgb_t              c_to;
    sla_pkg::rgb_t              rgb_next;

    assign out_free     = !out_valid_reg || pixel.ready;
    assign proc_fire    = in_valid_reg && out_free;
    assign status.ready = !in_valid_reg || out_free;

    assign pixel.valid      = out_valid_reg;
    assign pixel.red        = out_rgb_reg.red;
    assign pixel.green      = out_rgb_reg.green;
    assign pixel.blue       = out_rgb_reg.blue;
    assign pixel.pattern_id = out_pat_reg;

    always_comb
    begin
        pat = sla_pkg::pattern_sel(in_led_reg, in_relay_reg, in_wifi_reg,
                                   in_broker_reg, in_en_reg);
        n_steps     = sla_pkg::step_count(pat);
        pat_changed = (pat != prev_pat_reg);

        // A new pattern restarts at step 0 with the step starting now.
        if (pat_changed)
        begin
            step_eff  = '0;
            start_eff = in_now_reg;
        end
        else
        begin
            step_eff  = (step_reg >= n_steps) ? '0 : step_reg;
            start_eff = start_reg;
        end

        elapsed   = in_now_reg - start_eff;
        dur       = sla_pkg::step_length(pat, step_eff);
        step_done = (elapsed >= {22'd0, dur});
        step_inc  = (step_eff + 4'd1 == n_steps) ? '0 : step_eff + 4'd1;
        step_new  = step_done ? step_inc : step_eff;

        // Without an advance the elapsed time is below the step duration, at most 999.
        el = step_done ? '0 : elapsed[sla_pkg::ElW-1:0];

        // Fade quotient 80 * el / dur: 4 * el / 25 for 500 ms, 2 * el / 25 for 1000 ms.
        if (pat == sla_pkg::PAT_NO_BROKER)
            scaled = {el, 2'b00};
        else
            scaled = {1'b0, el, 1'b0};
        prod = scaled * sla_pkg::RECIP_25;
        q    = prod[sla_pkg::RecipShift +: sla_pkg::LevelW];

        c_from = sla_pkg::fade_from(pat, step_new);
        c_to   = sla_pkg::fade_to(pat, step_new);

        case (pat)
            sla_pkg::PAT_NO_BROKER, sla_pkg::PAT_IDLE:
            begin
                if (pat == sla_pkg::PAT_IDLE && step_new == 4'd4)
                    rgb_next = sla_pkg::RGB_BLACK;
                else
                begin
                    rgb_next.red   = (c_to.red > c_from.red) ? c_from.red + q :
                                     (c_to.red < c_from.red) ? c_from.red - q : c_from.red;
                    rgb_next.green = (c_to.green > c_from.green) ? c_from.green + q :
                                     (c_to.green < c_from.green) ? c_from.green - q :
                                     c_from.green;
                    rgb_next.blue  = (c_to.blue > c_from.blue) ? c_from.blue + q :
                                     (c_to.blue < c_from.blue) ? c_from.blue - q : c_from.blue;
                end
            end
            sla_pkg::PAT_OFF:
                rgb_next = sla_pkg::RGB_BLACK;
            default:
                rgb_next = sla_pkg::step_colour(pat, step_new);
        endcase

        // The off pattern leaves the step and its start time alone.
        if (pat == sla_pkg::PAT_OFF)
        begin
            prev_pat_next = sla_pkg::PAT_OFF;
            step_next     = step_reg;
            start_next    = start_reg;
        end
        else
        begin
            prev_pat_next = pat;
            step_next     = step_new;
            start_next    = step_done ? in_now_reg : start_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_pat_reg  <= sla_pkg::PAT_NONE;
            step_reg      <= '0;
            start_reg     <= '0;
        end
        else
        begin
            if (status.ready)
                in_valid_reg <= status.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (proc_fire)
            begin
                prev_pat_reg <= prev_pat_next;
                step_reg     <= step_next;
                start_reg    <= start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.valid && status.ready)
        begin
            in_now_reg    <= status.now_ms;
            in_led_reg    <= status.led_on;
            in_relay_reg  <= status.relay_on;
            in_wifi_reg   <= status.wifi_up;
            in_broker_reg <= status.broker_up;
            in_en_reg     <= status.enabled_flag;
        end
        if (proc_fire)
        begin
            out_rgb_reg <= rgb_next;
            out_pat_reg <= pat;
        end
    end

    a_levels_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_rgb_reg.red <= sla_pkg::LEVEL_ON) &&
                          (out_rgb_reg.green <= sla_pkg::LEVEL_ON) &&
                          (out_rgb_reg.blue <= sla_pkg::LEVEL_ON))
        else $error("pixel level above full scale");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (prev_pat_reg != sla_pkg::PAT_OFF && prev_pat_reg != sla_pkg::PAT_NONE) |->
            (step_reg < sla_pkg::step_count(prev_pat_reg)))
        else $error("step index beyond the step count of the current pattern");

    a_off_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_pat_reg == sla_pkg::PAT_OFF) |->
            (out_rgb_reg == sla_pkg::RGB_BLACK))
        else $error("off pattern drove a lit pixel");

    a_pattern_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire |=> (prev_pat_reg == out_pat_reg))
        else $error("stored pattern differs from the last pixel word");

    a_restart_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && pat_changed && pat != sla_pkg::PAT_OFF) |=>
            (step_reg == '0) && (start_reg == $past(in_now_reg)))
        else $error("pattern change did not restart the animation");

endmodule
